// ===== hw/rtl/i2c_master_register_access_core_macros.svh =====
// Assertion macros shared by the register access core.
`ifndef I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH
`define I2C_MASTER_REGISTER_ACCESS_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define I2CRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define I2CRA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/i2cra_pkg.sv =====
// Shared types and constants of the I2C register access core.
package i2cra_pkg;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned QPTRW  = 1;
	localparam int unsigned QCNTW  = 2;

	localparam logic [7:0] ACK_WAIT_RESET = 8'd250;

	typedef enum logic [2:0] {
		OP_TICK  = 3'd0,
		OP_LOAD  = 3'd1,
		OP_READ  = 3'd2,
		OP_WRITE = 3'd3,
		OP_BIT   = 3'd4
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [6:0] dev_addr;
		logic [7:0] reg_addr;
		logic [4:0] length;
		logic [7:0] data_byte;
		logic [2:0] bit_index;
		logic       bit_value;
		logic       sda_in;
	} item_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== hw/rtl/i2cra_front.sv =====
// Front end: accepts input items, decodes the command and clamps the length.
module i2cra_front
	import i2cra_pkg::*;
#(
	parameter int unsigned MAX_BURST = 16
) (
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,
	input  logic [2:0]  s_tuser,
	input  q_stat_t     q_stat,
	output logic        push,
	output item_t       push_item
);

	logic [4:0] len_in;
	logic [4:0] len_sat;

	assign s_tready = !q_stat.full;
	assign push     = s_tvalid && s_tready;
	assign len_in   = s_tdata[19:15];

	always_comb begin
		len_sat = len_in;
		if (32'(len_in) > MAX_BURST) begin
			len_sat = 5'(MAX_BURST);
		end
	end

	always_comb begin
		push_item.dev_addr  = s_tdata[6:0];
		push_item.reg_addr  = s_tdata[14:7];
		push_item.length    = len_sat;
		push_item.data_byte = s_tdata[27:20];
		push_item.bit_index = s_tdata[30:28];
		push_item.bit_value = s_tdata[31];
		push_item.sda_in    = s_tdata[32];
		unique case (s_tuser)
			OP_LOAD:  push_item.op = OP_LOAD;
			OP_READ:  push_item.op = OP_READ;
			OP_WRITE: push_item.op = OP_WRITE;
			OP_BIT: begin
				push_item.op     = OP_BIT;
				// bit change always moves one byte
				push_item.length = 5'd1;
			end
			default:  push_item.op = OP_TICK;
		endcase
	end

endmodule

// ===== hw/rtl/i2cra_fifo.sv =====
// Short queue of decoded items between front end and sequencer.
module i2cra_fifo
	import i2cra_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  item_t   push_item,
	input  logic    pop,
	output item_t   pop_item,
	output q_stat_t q_stat
);

	item_t             slots_q [QDEPTH];
	logic [QPTRW-1:0]  wr_ptr_q;
	logic [QPTRW-1:0]  rd_ptr_q;
	logic [QCNTW-1:0]  count_q;

	assign q_stat.full  = (count_q == QCNTW'(QDEPTH));
	assign q_stat.empty = (count_q == '0);
	assign pop_item     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (32'(wr_ptr_q) == QDEPTH - 1) ? '0 : wr_ptr_q + QPTRW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (32'(rd_ptr_q) == QDEPTH - 1) ? '0 : rd_ptr_q + QPTRW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + QCNTW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCNTW'(1);
			end
		end
	end

endmodule

// ===== hw/rtl/i2cra_seq.sv =====
// Back end: bus sequencer, write buffer and registered result stage.
module i2cra_seq
	import i2cra_pkg::*;
#(
	parameter int unsigned MAX_BURST = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  ack_limit,
	input  item_t       it,
	input  q_stat_t     q_stat,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,
	output logic        m_tuser,
	output logic        m_tlast
);

	localparam int unsigned IDXW  = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;
	localparam int unsigned FILLW = $clog2(MAX_BURST + 1);

	typedef enum logic [21:0] {
		PH_IDLE     = 22'h000001,
		PH_ST0      = 22'h000002,
		PH_ST1      = 22'h000004,
		PH_ST2      = 22'h000008,
		PH_TXLO     = 22'h000010,
		PH_TXHI     = 22'h000020,
		PH_ACKREL   = 22'h000040,
		PH_ACKHI    = 22'h000080,
		PH_ACKTAIL  = 22'h000100,
		PH_FAILTAIL = 22'h000200,
		PH_RXHI     = 22'h000400,
		PH_RXLO     = 22'h000800,
		PH_MA0      = 22'h001000,
		PH_MA1      = 22'h002000,
		PH_MA2      = 22'h004000,
		PH_MA3      = 22'h008000,
		PH_NA0      = 22'h010000,
		PH_NA1      = 22'h020000,
		PH_NA2      = 22'h040000,
		PH_SP0      = 22'h080000,
		PH_SP1      = 22'h100000,
		PH_SP2      = 22'h200000
	} phase_t;

	typedef enum logic [8:0] {
		SG_START   = 9'h001,
		SG_ADDRW   = 9'h002,
		SG_REG     = 9'h004,
		SG_RESTART = 9'h008,
		SG_ADDRR   = 9'h010,
		SG_RX      = 9'h020,
		SG_DATA    = 9'h040,
		SG_MIDSTOP = 9'h080,
		SG_FINAL   = 9'h100
	} stage_t;

	logic [7:0]       wbuf_q [MAX_BURST];

	phase_t           phase_q, n_phase;
	stage_t           stage_q, n_stage;
	logic [2:0]       bit_cnt_q, n_bit_cnt;
	logic [4:0]       byte_cnt_q, n_byte_cnt;
	logic [7:0]       shift_q, n_shift;
	logic [7:0]       ack_cnt_q, n_ack_cnt;
	logic [FILLW-1:0] fill_q, n_fill;
	logic [6:0]       dev_q, n_dev;
	logic [7:0]       reg_q, n_reg;
	logic [4:0]       len_q, n_len;
	logic [2:0]       bidx_q, n_bidx;
	logic             bval_q, n_bval;
	op_t              kind_q, n_kind;
	logic [7:0]       rmw_q, n_rmw;
	logic             failed_q, n_failed;
	logic             second_q, n_second;

	logic             buf_we;
	logic             seg_done, rx_done, next_wr;
	logic             msb;
	logic [7:0]       mask;
	logic [7:0]       wr_byte;
	logic             o_scl, o_sda, o_busy, o_valid, o_last, o_done, o_status;
	logic [7:0]       o_byte;

	assign pop = !q_stat.empty && (!m_tvalid || m_tready);
	assign msb = shift_q[7];

	always_comb begin
		n_phase    = phase_q;
		n_stage    = stage_q;
		n_bit_cnt  = bit_cnt_q;
		n_byte_cnt = byte_cnt_q;
		n_shift    = shift_q;
		n_ack_cnt  = ack_cnt_q;
		n_fill     = fill_q;
		n_dev      = dev_q;
		n_reg      = reg_q;
		n_len      = len_q;
		n_bidx     = bidx_q;
		n_bval     = bval_q;
		n_kind     = kind_q;
		n_rmw      = rmw_q;
		n_failed   = failed_q;
		n_second   = second_q;
		buf_we     = 1'b0;
		seg_done   = 1'b0;
		rx_done    = 1'b0;
		next_wr    = 1'b0;
		mask       = 8'd0;
		wr_byte    = 8'd0;
		o_scl      = 1'b1;
		o_sda      = 1'b1;
		o_valid    = 1'b0;
		o_byte     = 8'd0;
		o_last     = 1'b0;
		o_done     = 1'b0;
		o_status   = 1'b0;

		// commands count only between transactions
		if (phase_q == PH_IDLE) begin
			if (it.op == OP_LOAD) begin
				if (fill_q < FILLW'(MAX_BURST)) begin
					buf_we = 1'b1;
					n_fill = fill_q + FILLW'(1);
				end
			end else if (it.op inside {OP_READ, OP_WRITE, OP_BIT}) begin
				n_dev      = it.dev_addr;
				n_reg      = it.reg_addr;
				n_len      = it.length;
				n_bidx     = it.bit_index;
				n_bval     = it.bit_value;
				n_kind     = it.op;
				n_byte_cnt = 5'd0;
				n_bit_cnt  = 3'd0;
				n_ack_cnt  = 8'd0;
				n_failed   = 1'b0;
				n_second   = 1'b0;
				n_stage    = SG_START;
				n_phase    = PH_ST0;
			end
		end

		o_busy = (n_phase != PH_IDLE);

		unique case (n_phase)
			PH_ST0: begin
				n_phase = PH_ST1;
			end
			PH_ST1: begin
				o_sda   = 1'b0;
				n_phase = PH_ST2;
			end
			PH_ST2: begin
				o_scl    = 1'b0;
				o_sda    = 1'b0;
				seg_done = 1'b1;
			end
			PH_TXLO: begin
				o_scl   = 1'b0;
				o_sda   = msb;
				n_phase = PH_TXHI;
			end
			PH_TXHI: begin
				o_sda     = msb;
				n_shift   = {shift_q[6:0], 1'b0};
				n_bit_cnt = bit_cnt_q + 3'd1;
				if (n_bit_cnt == 3'd0) begin
					n_ack_cnt = 8'd0;
					n_phase   = PH_ACKREL;
				end else begin
					n_phase = PH_TXLO;
				end
			end
			PH_ACKREL: begin
				o_scl   = 1'b0;
				n_phase = PH_ACKHI;
			end
			PH_ACKHI: begin
				if (!it.sda_in) begin
					n_phase = PH_ACKTAIL;
				end else if (ack_cnt_q >= ack_limit) begin
					n_phase = PH_FAILTAIL;
				end else begin
					n_ack_cnt = ack_cnt_q + 8'd1;
				end
			end
			PH_ACKTAIL: begin
				o_scl    = 1'b0;
				seg_done = 1'b1;
			end
			PH_FAILTAIL: begin
				o_scl    = 1'b0;
				n_failed = 1'b1;
				n_stage  = SG_FINAL;
				n_phase  = PH_SP0;
			end
			PH_RXHI: begin
				n_shift   = {shift_q[6:0], it.sda_in};
				n_bit_cnt = bit_cnt_q + 3'd1;
				if (n_bit_cnt == 3'd0 && kind_q == OP_READ) begin
					o_valid = 1'b1;
					o_byte  = n_shift;
					o_last  = ({1'b0, byte_cnt_q} + 6'd1) == {1'b0, len_q};
				end
				n_phase = PH_RXLO;
			end
			PH_RXLO: begin
				o_scl = 1'b0;
				if (bit_cnt_q != 3'd0) begin
					n_phase = PH_RXHI;
				end else if (({1'b0, byte_cnt_q} + 6'd1) < {1'b0, len_q}) begin
					n_phase = PH_MA0;
				end else begin
					n_phase = PH_NA0;
				end
			end
			PH_MA0: begin
				o_scl   = 1'b0;
				o_sda   = 1'b0;
				n_phase = PH_MA1;
			end
			PH_MA1: begin
				o_sda   = 1'b0;
				n_phase = PH_MA2;
			end
			PH_MA2: begin
				o_scl   = 1'b0;
				o_sda   = 1'b0;
				n_phase = PH_MA3;
			end
			PH_MA3: begin
				o_scl   = 1'b0;
				rx_done = 1'b1;
			end
			PH_NA0: begin
				o_scl   = 1'b0;
				n_phase = PH_NA1;
			end
			PH_NA1: begin
				n_phase = PH_NA2;
			end
			PH_NA2: begin
				o_scl   = 1'b0;
				rx_done = 1'b1;
			end
			PH_SP0: begin
				o_scl   = 1'b0;
				o_sda   = 1'b0;
				n_phase = PH_SP1;
			end
			PH_SP1: begin
				o_sda   = 1'b0;
				n_phase = PH_SP2;
			end
			PH_SP2: begin
				seg_done = 1'b1;
			end
			default: begin
				n_phase = PH_IDLE;
			end
		endcase

		if (rx_done) begin
			n_byte_cnt = byte_cnt_q + 5'd1;
			if (n_byte_cnt < len_q) begin
				n_shift   = 8'd0;
				n_bit_cnt = 3'd0;
				n_phase   = PH_RXHI;
			end else if (kind_q == OP_BIT) begin
				// patch the byte just read, stop, then write it back
				mask       = 8'd1 << bidx_q;
				n_rmw      = bval_q ? (shift_q | mask) : (shift_q & ~mask);
				n_second   = 1'b1;
				n_byte_cnt = 5'd0;
				n_stage    = SG_MIDSTOP;
				n_phase    = PH_SP0;
			end else begin
				n_stage = SG_FINAL;
				n_phase = PH_SP0;
			end
		end

		if (seg_done) begin
			unique case (stage_q)
				SG_START: begin
					n_stage   = SG_ADDRW;
					n_shift   = {dev_q, 1'b0};
					n_bit_cnt = 3'd0;
					n_phase   = PH_TXLO;
				end
				SG_ADDRW: begin
					n_stage   = SG_REG;
					n_shift   = reg_q;
					n_bit_cnt = 3'd0;
					n_phase   = PH_TXLO;
				end
				SG_REG: begin
					if (kind_q == OP_WRITE || second_q) begin
						n_byte_cnt = 5'd0;
						next_wr    = 1'b1;
					end else begin
						n_stage = SG_RESTART;
						n_phase = PH_ST0;
					end
				end
				SG_RESTART: begin
					n_stage   = SG_ADDRR;
					n_shift   = {dev_q, 1'b1};
					n_bit_cnt = 3'd0;
					n_phase   = PH_TXLO;
				end
				SG_ADDRR: begin
					n_byte_cnt = 5'd0;
					if (len_q != 5'd0) begin
						n_stage   = SG_RX;
						n_shift   = 8'd0;
						n_bit_cnt = 3'd0;
						n_phase   = PH_RXHI;
					end else begin
						n_stage = SG_FINAL;
						n_phase = PH_SP0;
					end
				end
				SG_DATA: begin
					n_byte_cnt = byte_cnt_q + 5'd1;
					next_wr    = 1'b1;
				end
				SG_MIDSTOP: begin
					n_stage = SG_START;
					n_phase = PH_ST0;
				end
				default: begin
					o_done   = 1'b1;
					o_status = failed_q;
					if (kind_q == OP_WRITE) begin
						n_fill = '0;
					end
					n_phase = PH_IDLE;
					o_scl   = 1'b1;
					o_sda   = 1'b1;
				end
			endcase
		end

		if (next_wr) begin
			if (n_byte_cnt < len_q) begin
				wr_byte   = (kind_q == OP_WRITE) ? wbuf_q[IDXW'(n_byte_cnt)] : rmw_q;
				n_stage   = SG_DATA;
				n_shift   = wr_byte;
				n_bit_cnt = 3'd0;
				n_phase   = PH_TXLO;
			end else begin
				n_stage = SG_FINAL;
				n_phase = PH_SP0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && buf_we) begin
			wbuf_q[fill_q[IDXW-1:0]] <= it.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_IDLE;
			stage_q    <= SG_START;
			bit_cnt_q  <= 3'd0;
			byte_cnt_q <= 5'd0;
			shift_q    <= 8'd0;
			ack_cnt_q  <= 8'd0;
			fill_q     <= '0;
			dev_q      <= 7'd0;
			reg_q      <= 8'd0;
			len_q      <= 5'd0;
			bidx_q     <= 3'd0;
			bval_q     <= 1'b0;
			kind_q     <= OP_TICK;
			rmw_q      <= 8'd0;
			failed_q   <= 1'b0;
			second_q   <= 1'b0;
		end else if (pop) begin
			phase_q    <= n_phase;
			stage_q    <= n_stage;
			bit_cnt_q  <= n_bit_cnt;
			byte_cnt_q <= n_byte_cnt;
			shift_q    <= n_shift;
			ack_cnt_q  <= n_ack_cnt;
			fill_q     <= n_fill;
			dev_q      <= n_dev;
			reg_q      <= n_reg;
			len_q      <= n_len;
			bidx_q     <= n_bidx;
			bval_q     <= n_bval;
			kind_q     <= n_kind;
			rmw_q      <= n_rmw;
			failed_q   <= n_failed;
			second_q   <= n_second;
		end
	end

	// result register: refill whenever it is empty or being taken and an item waits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (pop) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			m_tdata <= {3'b000, o_status, o_done, o_byte, o_busy, o_sda, o_scl};
			m_tuser <= o_valid;
			m_tlast <= o_last;
		end
	end

endmodule

// ===== hw/rtl/i2c_master_register_access_core.sv =====
// I2C master register access core: front end, item queue and bus sequencer.
// Each input item yields one result item, registered when the sequencer takes the item from the queue.
// Throughput is one item per cycle unless the result side stalls; the sequencer steps once per item.
// A two-entry queue and the result register let either side stall on its own.
// arst_n clears the queue, the sequencer (bus released, buffer empty) and sets the wait limit to 250.
// The write buffer holds no reset; only loaded entries are meaningful.
`include "i2c_master_register_access_core_macros.svh"

module i2c_master_register_access_core
	import i2cra_pkg::*;
#(
	parameter int unsigned MAX_BURST = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,   // ack_wait_limit
	input  logic        s_tvalid,
	output logic        s_tready,
	// dev_addr[6:0], reg_addr[14:7], length[19:15], data_byte[27:20],
	// bit_index[30:28], bit_value[31], sda_in[32], zero fill [39:33]
	input  logic [39:0] s_tdata,
	input  logic [2:0]  s_tuser,    // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	// scl_level[0], sda_drive[1], busy_res[2], read_byte[10:3], done_res[11],
	// status[12], zero fill [15:13]
	output logic [15:0] m_tdata,
	output logic        m_tuser,    // read_valid
	output logic        m_tlast     // read_last
);

	logic [7:0] ack_limit_q;
	logic       push;
	logic       pop;
	item_t      push_item;
	item_t      pop_item;
	q_stat_t    q_stat;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ack_limit_q <= ACK_WAIT_RESET;
		end else if (cfg_valid && cfg_ready) begin
			ack_limit_q <= cfg_data;
		end
	end

	i2cra_front #(
		.MAX_BURST(MAX_BURST)
	) u_front (
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.q_stat   (q_stat),
		.push     (push),
		.push_item(push_item)
	);

	i2cra_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_item(push_item),
		.pop      (pop),
		.pop_item (pop_item),
		.q_stat   (q_stat)
	);

	i2cra_seq #(
		.MAX_BURST(MAX_BURST)
	) u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.ack_limit(ack_limit_q),
		.it       (pop_item),
		.q_stat   (q_stat),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	`I2CRA_ASSERT_NEXT(a_push_fills_queue, s_tvalid && s_tready, !q_stat.empty, "accepted item missing from queue")
	`I2CRA_ASSERT_NOW(a_pop_needs_item, pop, !q_stat.empty, "sequencer stepped on an empty queue")
	`I2CRA_ASSERT_NOW(a_status_with_done, m_tvalid && m_tdata[12], m_tdata[11], "error status without done")
	`I2CRA_ASSERT_NOW(a_read_while_busy, m_tvalid && m_tuser, m_tdata[2] && m_tdata[0], "read byte outside a transaction")

endmodule
